### src/lmsap_pkg.sv
// Package for the LMS adaptive predictor: beat types, codes and the control program.
package lmsap_pkg;

  localparam int ORDER_DEF = 8;
  localparam logic [15:0] STEP_RESET = 16'd3277;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] sample;
    logic        [5:0]  coef_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] error;
    logic signed [15:0] prediction;
    logic signed [31:0] coef_value;
  } out_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_PRED,
    DP_FINISH,
    DP_MUERR,
    DP_UPD,
    DP_SHIFT,
    DP_READ,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    FL_NEXT,
    FL_JUMP,
    FL_LOOP,
    FL_DISPATCH,
    FL_EMIT
  } flow_t;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE   = 3'd0;
  localparam pc_t PC_PRED   = 3'd1;
  localparam pc_t PC_FINISH = 3'd2;
  localparam pc_t PC_MUERR  = 3'd3;
  localparam pc_t PC_UPD    = 3'd4;
  localparam pc_t PC_SHIFT  = 3'd5;
  localparam pc_t PC_READ   = 3'd6;
  localparam pc_t PC_EMIT   = 3'd7;

  typedef struct packed {
    dp_op_t op;
    flow_t  flow;
    pc_t    target;
  } uword_t;

  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    case (pc)
      PC_IDLE:   w = '{op: DP_IDLE,   flow: FL_DISPATCH, target: PC_READ};
      PC_PRED:   w = '{op: DP_PRED,   flow: FL_LOOP,     target: PC_FINISH};
      PC_FINISH: w = '{op: DP_FINISH, flow: FL_NEXT,     target: PC_IDLE};
      PC_MUERR:  w = '{op: DP_MUERR,  flow: FL_NEXT,     target: PC_IDLE};
      PC_UPD:    w = '{op: DP_UPD,    flow: FL_LOOP,     target: PC_SHIFT};
      PC_SHIFT:  w = '{op: DP_SHIFT,  flow: FL_JUMP,     target: PC_EMIT};
      PC_READ:   w = '{op: DP_READ,   flow: FL_LOOP,     target: PC_EMIT};
      PC_EMIT:   w = '{op: DP_EMIT,   flow: FL_EMIT,     target: PC_IDLE};
      default:   w = '{op: DP_IDLE,   flow: FL_JUMP,     target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### src/lms_adaptive_predictor_core.sv
// LMS adaptive linear predictor core: microcoded sequencer; predict and update share one multiplier.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_ready   in_data  (operation, sample, coef_index)
//   out      output     out_valid/out_ready out_data (error, prediction, coef_value)
//   cfg      input      cfg_we              cfg_data (step_size)
//
// Sample beat: predict pass over the taps on the shared multiplier, finish, step-times-error,
// update pass over the taps on the shared multiplier, delay-line shift, emit. Read beat: scan, emit.
// Next beat is accepted the cycle after the result is loaded into the output register.
// Synchronous reset clears coefficients, delay line and step size to its reset value.
// A stalled output holds the sequencer in its emit step; input is taken only when idle.
module lms_adaptive_predictor_core #(
  parameter int ORDER = lmsap_pkg::ORDER_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lmsap_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lmsap_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data
);
  import lmsap_pkg::*;

  localparam int CNT_W  = $clog2(ORDER + 1);
  localparam int PROD_W = 49;
  localparam int ACC_W  = 48 + $clog2(ORDER + 1);

  logic [15:0]              step_size;
  logic signed [31:0]       coefs [ORDER];
  logic signed [15:0]       samps [ORDER];
  pc_t                      pc, pc_next;
  logic [CNT_W-1:0]         cnt, cnt_next;
  uword_t                   uw;
  logic                     at_end, head, tail, accept, emit_ok, idx_hit;

  logic                     op_r;
  logic signed [15:0]       x_r;
  logic [5:0]               idx_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [15:0]       pred_r, err_r;
  logic signed [32:0]       mu_err;
  logic signed [31:0]       coef_r;

  logic signed [32:0]       mul_a;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  pred_sh;
  logic signed [15:0]       pred_sat, err_sat;
  logic signed [16:0]       err_full;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [33:0]       csum;
  logic signed [31:0]       coef_upd;

  // sequencer
  always_comb begin
    uw       = ucode_rom(pc);
    at_end   = (cnt == CNT_W'(ORDER));
    head     = !at_end;
    tail     = (cnt != '0);
    in_ready = (uw.flow == FL_DISPATCH) && !rst;
    accept   = in_valid && in_ready;
    emit_ok  = !out_valid || out_ready;
    idx_hit  = (32'(cnt) == 32'(idx_r));
    pc_next  = pc;
    cnt_next = cnt;
    case (uw.flow)
      FL_NEXT: pc_next = pc + 1'b1;
      FL_JUMP: pc_next = uw.target;
      FL_LOOP: begin
        if (at_end) begin
          cnt_next = '0;
          pc_next  = uw.target;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      FL_DISPATCH: begin
        cnt_next = '0;
        if (accept) begin
          pc_next = (in_data.operation == OP_READ) ? uw.target : pc + 1'b1;
        end
      end
      FL_EMIT: if (emit_ok) pc_next = uw.target;
      default: pc_next = PC_IDLE;
    endcase
  end

  // datapath arithmetic
  always_comb begin
    mul_a = (uw.op == DP_UPD) ? mu_err : 33'(coefs[0]);
    mul_p = mul_a * samps[0];

    pred_sh = (acc + ACC_W'(1 << 23)) >>> 24;
    if (pred_sh > ACC_W'(32767)) begin
      pred_sat = 16'sh7fff;
    end else if (pred_sh < ACC_W'(-32768)) begin
      pred_sat = -16'sh8000;
    end else begin
      pred_sat = pred_sh[15:0];
    end

    err_full = 17'(x_r) - 17'(pred_sat);
    if (err_full > 17'sd32767) begin
      err_sat = 16'sh7fff;
    end else if (err_full < -17'sd32768) begin
      err_sat = -16'sh8000;
    end else begin
      err_sat = err_full[15:0];
    end

    prod_rnd = (prod + PROD_W'(1 << 21)) >>> 22;
    csum     = 34'(coefs[0]) + 34'(prod_rnd);
    if (csum > 34'sd2147483647) begin
      coef_upd = 32'sh7fffffff;
    end else if (csum < -34'sd2147483648) begin
      coef_upd = -32'sh80000000;
    end else begin
      coef_upd = csum[31:0];
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_IDLE;
      cnt       <= '0;
      step_size <= STEP_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        coefs[i] <= '0;
        samps[i] <= '0;
      end
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
      if (cfg_we) step_size <= cfg_data;
      if (uw.op == DP_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (uw.op)
        DP_PRED: begin
          if (head) begin
            for (int i = 0; i < ORDER - 1; i++) begin
              coefs[i] <= coefs[i+1];
              samps[i] <= samps[i+1];
            end
            coefs[ORDER-1] <= coefs[0];
            samps[ORDER-1] <= samps[0];
          end
        end
        DP_UPD: begin
          if (head) begin
            for (int i = 0; i < ORDER - 1; i++) samps[i] <= samps[i+1];
            samps[ORDER-1] <= samps[0];
          end
          if (tail) begin
            for (int i = 0; i < ORDER - 1; i++) coefs[i] <= coefs[i+1];
            coefs[ORDER-1] <= coef_upd;
          end
        end
        DP_SHIFT: begin
          for (int i = ORDER - 1; i > 0; i--) samps[i] <= samps[i-1];
          samps[0] <= x_r;
        end
        DP_READ: begin
          if (head) begin
            for (int i = 0; i < ORDER - 1; i++) coefs[i] <= coefs[i+1];
            coefs[ORDER-1] <= coefs[0];
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (uw.op)
      DP_IDLE: begin
        if (accept) begin
          op_r   <= in_data.operation;
          x_r    <= in_data.sample;
          idx_r  <= in_data.coef_index;
          acc    <= '0;
          prod   <= '0;
          coef_r <= '0;
        end
      end
      DP_PRED: begin
        if (head) prod <= mul_p;
        if (tail) acc <= acc + ACC_W'(prod);
      end
      DP_FINISH: begin
        pred_r <= pred_sat;
        err_r  <= err_sat;
      end
      DP_MUERR: mu_err <= $signed({1'b0, step_size}) * err_r;
      DP_UPD: if (head) prod <= mul_p;
      DP_READ: if (head && idx_hit) coef_r <= coefs[0];
      DP_EMIT: begin
        if (emit_ok) begin
          out_data.error      <= (op_r == OP_READ) ? 16'sd0 : err_r;
          out_data.prediction <= (op_r == OP_READ) ? 16'sd0 : pred_r;
          out_data.coef_value <= (op_r == OP_READ) ? coef_r : 32'sd0;
        end
      end
      default: ;
    endcase
  end

endmodule
